>>> rtl/lsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types and constants of the lottery slot arbiter.
// ----------------------------------------------------------------------------
package lsa_pkg;

   localparam int IDX_W  = 9;
   localparam int BL_W   = 10;
   localparam int RATE_W = 6;
   localparam int RND_W  = 32;
   localparam int SUM_W  = 19;
   localparam int CNT_W  = 32;
   localparam int STEP_W = $clog2(RND_W);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_SLOT = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_RD,
      ST_LD_WR,
      ST_DIV,
      ST_WALK,
      ST_SEND,
      ST_OUT
   } state_type;

   // one stored entry: backlog in the upper bits, rate in the lower
   typedef struct packed {
      logic [BL_W-1:0]   backlog;
      logic [RATE_W-1:0] rate;
   } entry_type;

endpackage
`default_nettype wire

>>> rtl/lottery_slot_arbiter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lottery_slot_arbiter
// Weighted random slot arbiter over NUM_TX transmitter entries held in RAM.
// ----------------------------------------------------------------------------
// One word at a time. After reset the entry RAM is swept to zero, one entry
// per cycle, with req_stall high. A load word holds req_stall after it is
// taken while it reads the old backlog, writes the new one and then fills the
// response register; an index of NUM_TX or more goes straight to the response
// register. A slot word runs the bit-serial reduction of the random word
// modulo the total backlog, then the walk over the stored backlogs (one RAM
// read per cycle), then the write-back (only when the send coin is set) and
// the response. A slot with zero total backlog skips the reduction, walk and
// write-back. A finished response waits in its output register; the next
// word is taken meanwhile, and its own response waits until that register is
// free.
module lottery_slot_arbiter #(
   parameter int NUM_TX = 512
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_opcode,
   input  wire  [lsa_pkg::IDX_W-1:0]    req_entry_index,
   input  wire  [lsa_pkg::BL_W-1:0]     req_entry_backlog,
   input  wire  [lsa_pkg::RATE_W-1:0]   req_entry_rate,
   input  wire  [lsa_pkg::RND_W-1:0]    req_random_word,
   input  wire                          req_send_coin,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [lsa_pkg::IDX_W-1:0]    rsp_chosen_index,
   output logic                         rsp_chosen_valid,
   output logic [lsa_pkg::RATE_W-1:0]   rsp_units_sent,
   output logic [lsa_pkg::SUM_W-1:0]    rsp_total_backlog,
   output logic                         rsp_all_done,
   output logic [lsa_pkg::CNT_W-1:0]    rsp_slots_elapsed
);
   import lsa_pkg::*;

   localparam int AW = (NUM_TX > 1) ? $clog2(NUM_TX) : 1;

   // entry RAM
   entry_type         entry_mem [NUM_TX];
   entry_type         rd_data_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   entry_type         mem_wdata;
   logic [AW-1:0]     mem_raddr;

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  slot_cnt_ff, slot_cnt_in;
   logic [AW-1:0]     ld_addr_ff, ld_addr_in;
   logic [BL_W-1:0]   ld_bl_ff, ld_bl_in;
   logic [RATE_W-1:0] ld_rt_ff, ld_rt_in;
   logic              coin_ff, coin_in;
   logic [RND_W-1:0]  div_ff, div_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [AW:0]       rd_addr_ff, rd_addr_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [AW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [SUM_W:0]    base_ff, base_in;
   logic [AW-1:0]     pick_idx_ff, pick_idx_in;
   logic              pick_valid_ff, pick_valid_in;
   entry_type         pick_ff, pick_in;
   logic [RATE_W-1:0] sent_ff, sent_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic              rsp_cv_ff, rsp_cv_in;
   logic [RATE_W-1:0] rsp_sent_ff, rsp_sent_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;
   logic              rsp_done_ff, rsp_done_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   logic              req_take;
   logic [SUM_W:0]    trial;
   logic [SUM_W:0]    span_end;
   logic [RATE_W-1:0] take_units;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         sum_ff        <= '0;
         slot_cnt_ff   <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         sum_ff        <= sum_in;
         slot_cnt_ff   <= slot_cnt_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ld_addr_ff    <= ld_addr_in;
      ld_bl_ff      <= ld_bl_in;
      ld_rt_ff      <= ld_rt_in;
      coin_ff       <= coin_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      rd_addr_ff    <= rd_addr_in;
      cmp_idx_ff    <= cmp_idx_in;
      base_ff       <= base_in;
      pick_idx_ff   <= pick_idx_in;
      pick_valid_ff <= pick_valid_in;
      pick_ff       <= pick_in;
      sent_ff       <= sent_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_cv_ff     <= rsp_cv_in;
      rsp_sent_ff   <= rsp_sent_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // restoring division step: shift in one dividend bit
   assign trial      = {rem_ff, div_ff[RND_W-1]};
   assign span_end   = base_ff + (SUM_W+1)'(rd_data_ff.backlog);
   assign take_units = (RATE_W'(pick_ff.backlog) > pick_ff.rate
                        || pick_ff.backlog > BL_W'(pick_ff.rate))
                       ? pick_ff.rate : RATE_W'(pick_ff.backlog);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      sum_in        = sum_ff;
      slot_cnt_in   = slot_cnt_ff;
      ld_addr_in    = ld_addr_ff;
      ld_bl_in      = ld_bl_ff;
      ld_rt_in      = ld_rt_ff;
      coin_in       = coin_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      rd_addr_in    = rd_addr_ff;
      rd_pend_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      base_in       = base_ff;
      pick_idx_in   = pick_idx_ff;
      pick_valid_in = pick_valid_ff;
      pick_in       = pick_ff;
      sent_in       = sent_ff;
      mem_we        = 1'b0;
      mem_waddr     = ld_addr_ff;
      mem_wdata     = '0;
      mem_raddr     = ld_addr_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_idx_in    = rsp_idx_ff;
      rsp_cv_in     = rsp_cv_ff;
      rsp_sent_in   = rsp_sent_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_cnt_in    = rsp_cnt_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(NUM_TX - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               ld_addr_in    = AW'(req_entry_index);
               ld_bl_in      = req_entry_backlog;
               ld_rt_in      = req_entry_rate;
               coin_in       = req_send_coin;
               div_in        = req_random_word;
               rem_in        = '0;
               step_in       = '0;
               rd_addr_in    = '0;
               base_in       = '0;
               pick_idx_in   = '0;
               pick_valid_in = 1'b0;
               sent_in       = '0;
               if (req_opcode == OP_LOAD) begin
                  state_in = (int'(req_entry_index) < NUM_TX) ? ST_LD_RD : ST_OUT;
               end else begin
                  slot_cnt_in = slot_cnt_ff + CNT_W'(1);
                  state_in    = (sum_ff != '0) ? ST_DIV : ST_OUT;
               end
            end
         end
         ST_LD_RD: begin
            mem_raddr = ld_addr_ff;
            state_in  = ST_LD_WR;
         end
         ST_LD_WR: begin
            sum_in            = sum_ff - SUM_W'(rd_data_ff.backlog) + SUM_W'(ld_bl_ff);
            mem_we            = 1'b1;
            mem_waddr         = ld_addr_ff;
            mem_wdata.backlog = ld_bl_ff;
            mem_wdata.rate    = ld_rt_ff;
            state_in          = ST_OUT;
         end
         ST_DIV: begin
            if (trial >= {1'b0, sum_ff}) begin
               rem_in = SUM_W'(trial - {1'b0, sum_ff});
            end else begin
               rem_in = trial[SUM_W-1:0];
            end
            div_in  = {div_ff[RND_W-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(RND_W - 1)) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // rem_ff holds the drawn point; reads stream one entry per cycle
            mem_raddr = rd_addr_ff[AW-1:0];
            if (rd_pend_ff && ({1'b0, rem_ff} < span_end)) begin
               pick_idx_in   = cmp_idx_ff;
               pick_valid_in = 1'b1;
               pick_in       = rd_data_ff;
               state_in      = ST_SEND;
            end else begin
               if (rd_pend_ff) begin
                  base_in = span_end;
               end
               if (int'(rd_addr_ff) < NUM_TX) begin
                  rd_pend_in = 1'b1;
                  cmp_idx_in = rd_addr_ff[AW-1:0];
                  rd_addr_in = rd_addr_ff + (AW+1)'(1);
               end else if (!rd_pend_ff) begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_SEND: begin
            if (coin_ff) begin
               sent_in           = take_units;
               sum_in            = sum_ff - SUM_W'(take_units);
               mem_we            = 1'b1;
               mem_waddr         = pick_idx_ff;
               mem_wdata.backlog = pick_ff.backlog - BL_W'(take_units);
               mem_wdata.rate    = pick_ff.rate;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = IDX_W'(pick_idx_ff);
               rsp_cv_in    = pick_valid_ff;
               rsp_sent_in  = sent_ff;
               rsp_sum_in   = sum_ff;
               rsp_done_in  = (sum_ff == '0);
               rsp_cnt_in   = slot_cnt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_index  = rsp_idx_ff;
   assign rsp_chosen_valid  = rsp_cv_ff;
   assign rsp_units_sent    = rsp_sent_ff;
   assign rsp_total_backlog = rsp_sum_ff;
   assign rsp_all_done      = rsp_done_ff;
   assign rsp_slots_elapsed = rsp_cnt_ff;

endmodule
`default_nettype wire
